FILE: design/bpq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpq_pkg
// Shared constants for the bucket priority queue: field widths, default
// sizes, action and status codes.
// ----------------------------------------------------------------------------
package bpq_pkg;

   localparam int ACTION_W = 2;
   localparam int CELL_W   = 10;
   localparam int PRIO_W   = 8;
   localparam int STATUS_W = 2;

   localparam int DEF_CELL_COUNT   = 1024;
   localparam int DEF_BUCKET_COUNT = 256;

   // request actions
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_POP    = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_CHANGE = 2'd3;

   // response status
   localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_POPPED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;

endpackage
`default_nettype wire

FILE: design/bpq_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpq_req_if
// Request channel of the bucket priority queue: valid/ready plus payload.
// ----------------------------------------------------------------------------
interface bpq_req_if;
   logic                           valid;
   logic                           ready;
   logic [bpq_pkg::ACTION_W-1:0]   action;
   logic [bpq_pkg::CELL_W-1:0]     cell_req;
   logic [bpq_pkg::PRIO_W-1:0]     new_priority;
   logic [bpq_pkg::PRIO_W-1:0]     old_priority;

   modport source (output valid, output action, output cell_req,
                   output new_priority, output old_priority, input ready);
   modport sink   (input valid, input action, input cell_req,
                   input new_priority, input old_priority, output ready);
endinterface
`default_nettype wire

FILE: design/bpq_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpq_rsp_if
// Response channel of the bucket priority queue: valid/ready plus payload.
// ----------------------------------------------------------------------------
interface bpq_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [bpq_pkg::STATUS_W-1:0]   status;
   logic [bpq_pkg::CELL_W-1:0]     popped_cell;

   modport source (output valid, output status, output popped_cell, input ready);
   modport sink   (input valid, input status, input popped_cell, output ready);
endinterface
`default_nettype wire

FILE: design/bpq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpq_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module bpq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

FILE: design/bucket_priority_queue_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bucket_priority_queue_top
// Bucket priority queue of cell indices kept in two synchronous RAMs.
// ----------------------------------------------------------------------------
// One request is worked at a time by a sequencer around two RAMs: a bucket
// head RAM (BUCKET_COUNT entries) and a per-cell link RAM (CELL_COUNT
// entries), each with a registered read. Every request gives one response
// through an output register, so a waiting response does not block the
// sequencer until the next one is ready. Insert reads the bucket head, then
// links the cell in front of it and writes the cell as the new head. Pop
// scans from the lowest-bucket pointer past empty buckets, then reads the
// head's link and writes it back as the new head, or reports empty when no
// cell is left. Change finds the cell at the head of its old bucket or by
// walking the links past the head (up to CELL_COUNT links), unlinks it when
// found, then inserts it as for insert. Clear sweeps the head RAM one entry
// per cycle. The next request is taken from the cycle after the response is
// raised, also while that response is still held. The same sweep runs after
// reset, during which no request is taken.
// ----------------------------------------------------------------------------
module bucket_priority_queue_top #(
   parameter int CELL_COUNT   = bpq_pkg::DEF_CELL_COUNT,
   parameter int BUCKET_COUNT = bpq_pkg::DEF_BUCKET_COUNT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   bpq_req_if.sink    req_bus,
   bpq_rsp_if.source  rsp_bus
);

   localparam int CIW   = $clog2(CELL_COUNT);
   localparam int BIW   = $clog2(BUCKET_COUNT);
   localparam int LW    = CIW + 1;
   localparam int STW   = $clog2(CELL_COUNT);
   localparam int CELLW = bpq_pkg::CELL_W;
   localparam int PRIOW = bpq_pkg::PRIO_W;
   localparam int STATW = bpq_pkg::STATUS_W;

   localparam logic [LW-1:0]  NIL_LINK   = {1'b1, {CIW{1'b0}}};
   localparam logic [BIW:0]   LOW_END    = (BIW+1)'(BUCKET_COUNT);
   localparam logic [BIW-1:0] LAST_BKT   = BIW'(BUCKET_COUNT - 1);
   localparam logic [STW-1:0] LAST_STEP  = STW'(CELL_COUNT - 1);

   localparam logic [3:0] S_IDLE          = 4'd0;
   localparam logic [3:0] S_CLEAR         = 4'd1;
   localparam logic [3:0] S_PUSH          = 4'd2;
   localparam logic [3:0] S_PUSH_WR       = 4'd3;
   localparam logic [3:0] S_POP_CHK       = 4'd4;
   localparam logic [3:0] S_POP_HEAD      = 4'd5;
   localparam logic [3:0] S_POP_LINK      = 4'd6;
   localparam logic [3:0] S_DROP_START    = 4'd7;
   localparam logic [3:0] S_DROP_HEAD     = 4'd8;
   localparam logic [3:0] S_DROP_HEADLINK = 4'd9;
   localparam logic [3:0] S_DROP_WALK     = 4'd10;
   localparam logic [3:0] S_DROP_UNLINK   = 4'd11;
   localparam logic [3:0] S_DONE          = 4'd12;

   // control state
   logic [3:0]       state_ff, state_in;
   logic [BIW-1:0]   sweep_ff, sweep_in;
   logic             clr_rsp_ff, clr_rsp_in;
   logic [BIW:0]     lowest_ff, lowest_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // request and work registers
   logic [CELLW-1:0] cell_req_ff, cell_req_in;
   logic [PRIOW-1:0] newp_ff, newp_in;
   logic [PRIOW-1:0] oldp_ff, oldp_in;
   logic [CIW-1:0]   cur_ff, cur_in;
   logic [STW-1:0]   steps_ff, steps_in;
   logic [STATW-1:0] status_ff, status_in;
   logic [CELLW-1:0] popped_ff, popped_in;
   logic [STATW-1:0] rsp_status_ff, rsp_status_in;
   logic [CELLW-1:0] rsp_popped_ff, rsp_popped_in;

   // ram ports
   logic             hw_en;
   logic [BIW-1:0]   hw_addr, hr_addr;
   logic [LW-1:0]    hw_data, head_rd;
   logic             lw_en;
   logic [CIW-1:0]   lw_addr, lr_addr;
   logic [LW-1:0]    lw_data, link_rd;

   logic             req_fire, out_free, cell_ok, old_ok;
   logic [CIW-1:0]   cell_idx;
   logic [BIW-1:0]   push_bkt, old_bkt;
   logic [BIW:0]     low_next;

   bpq_ram #(.WIDTH(LW), .DEPTH(BUCKET_COUNT)) u_heads (
      .clock   (clock),
      .wr_en   (hw_en),
      .wr_addr (hw_addr),
      .wr_data (hw_data),
      .rd_addr (hr_addr),
      .rd_data (head_rd)
   );

   bpq_ram #(.WIDTH(LW), .DEPTH(CELL_COUNT)) u_links (
      .clock   (clock),
      .wr_en   (lw_en),
      .wr_addr (lw_addr),
      .wr_data (lw_data),
      .rd_addr (lr_addr),
      .rd_data (link_rd)
   );

   assign req_bus.ready       = (state_ff == S_IDLE);
   assign req_fire            = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.popped_cell = rsp_popped_ff;
   assign out_free            = !rsp_valid_ff || rsp_bus.ready;

   assign cell_ok  = 32'(cell_req_ff) < 32'(CELL_COUNT);
   assign cell_idx = CIW'(cell_req_ff);
   assign old_ok   = 32'(oldp_ff) < 32'(BUCKET_COUNT);
   assign old_bkt  = BIW'(oldp_ff);
   // out-of-range priorities land in the top bucket
   assign push_bkt = (32'(newp_ff) >= 32'(BUCKET_COUNT)) ? LAST_BKT : BIW'(newp_ff);
   assign low_next = lowest_ff + 1'b1;

   always_comb begin
      state_in      = state_ff;
      sweep_in      = sweep_ff;
      clr_rsp_in    = clr_rsp_ff;
      lowest_in     = lowest_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      cell_req_in   = cell_req_ff;
      newp_in       = newp_ff;
      oldp_in       = oldp_ff;
      cur_in        = cur_ff;
      steps_in      = steps_ff;
      status_in     = status_ff;
      popped_in     = popped_ff;
      rsp_status_in = rsp_status_ff;
      rsp_popped_in = rsp_popped_ff;
      hw_en         = 1'b0;
      hw_addr       = push_bkt;
      hw_data       = NIL_LINK;
      hr_addr       = push_bkt;
      lw_en         = 1'b0;
      lw_addr       = cell_idx;
      lw_data       = head_rd;
      lr_addr       = cell_idx;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cell_req_in = req_bus.cell_req;
               newp_in     = req_bus.new_priority;
               oldp_in     = req_bus.old_priority;
               status_in   = bpq_pkg::ST_DONE;
               popped_in   = '0;
               unique case (req_bus.action)
                  bpq_pkg::ACT_CLEAR: begin
                     sweep_in   = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = S_CLEAR;
                  end
                  bpq_pkg::ACT_INSERT: state_in = S_PUSH;
                  bpq_pkg::ACT_POP:    state_in = S_POP_CHK;
                  bpq_pkg::ACT_CHANGE: state_in = S_DROP_START;
                  default:             state_in = S_IDLE;
               endcase
            end
         end
         S_CLEAR: begin
            hw_en   = 1'b1;
            hw_addr = sweep_ff;
            hw_data = NIL_LINK;
            if (sweep_ff == LAST_BKT) begin
               lowest_in  = '0;
               clr_rsp_in = 1'b0;
               state_in   = clr_rsp_ff ? S_DONE : S_IDLE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         S_PUSH: begin
            hr_addr = push_bkt;
            if (!cell_ok) begin
               state_in = S_DONE;
            end else begin
               if ({1'b0, push_bkt} < lowest_ff) begin
                  lowest_in = {1'b0, push_bkt};
               end
               state_in = S_PUSH_WR;
            end
         end
         S_PUSH_WR: begin
            lw_en    = 1'b1;
            lw_addr  = cell_idx;
            lw_data  = head_rd;
            hw_en    = 1'b1;
            hw_addr  = push_bkt;
            hw_data  = {1'b0, cell_idx};
            state_in = S_DONE;
         end
         S_POP_CHK: begin
            hr_addr = lowest_ff[BIW-1:0];
            if (lowest_ff == LOW_END) begin
               status_in = bpq_pkg::ST_EMPTY;
               state_in  = S_DONE;
            end else begin
               state_in = S_POP_HEAD;
            end
         end
         S_POP_HEAD: begin
            // empty bucket: step the pointer and read the next head at once
            hr_addr = low_next[BIW-1:0];
            lr_addr = head_rd[CIW-1:0];
            if (head_rd[CIW]) begin
               lowest_in = low_next;
               if (low_next == LOW_END) begin
                  status_in = bpq_pkg::ST_EMPTY;
                  state_in  = S_DONE;
               end
            end else begin
               cur_in   = head_rd[CIW-1:0];
               state_in = S_POP_LINK;
            end
         end
         S_POP_LINK: begin
            hw_en     = 1'b1;
            hw_addr   = lowest_ff[BIW-1:0];
            hw_data   = link_rd;
            status_in = bpq_pkg::ST_POPPED;
            popped_in = CELLW'(cur_ff);
            state_in  = S_DONE;
         end
         S_DROP_START: begin
            hr_addr = old_bkt;
            if (!cell_ok) begin
               state_in = S_DONE;
            end else if (!old_ok) begin
               state_in = S_PUSH;
            end else begin
               state_in = S_DROP_HEAD;
            end
         end
         S_DROP_HEAD: begin
            if (head_rd[CIW]) begin
               state_in = S_PUSH;
            end else if (head_rd == {1'b0, cell_idx}) begin
               lr_addr  = cell_idx;
               state_in = S_DROP_HEADLINK;
            end else begin
               cur_in   = head_rd[CIW-1:0];
               lr_addr  = head_rd[CIW-1:0];
               steps_in = '0;
               state_in = S_DROP_WALK;
            end
         end
         S_DROP_HEADLINK: begin
            hw_en    = 1'b1;
            hw_addr  = old_bkt;
            hw_data  = link_rd;
            state_in = S_PUSH;
         end
         S_DROP_WALK: begin
            // link_rd is the successor of cur_ff
            if (link_rd[CIW]) begin
               state_in = S_PUSH;
            end else if (link_rd == {1'b0, cell_idx}) begin
               lr_addr  = cell_idx;
               state_in = S_DROP_UNLINK;
            end else if (steps_ff == LAST_STEP) begin
               // walk bound guards against a cyclic list
               state_in = S_PUSH;
            end else begin
               cur_in   = link_rd[CIW-1:0];
               lr_addr  = link_rd[CIW-1:0];
               steps_in = steps_ff + 1'b1;
            end
         end
         S_DROP_UNLINK: begin
            lw_en    = 1'b1;
            lw_addr  = cur_ff;
            lw_data  = link_rd;
            state_in = S_PUSH;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_popped_in = popped_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         sweep_ff     <= '0;
         clr_rsp_ff   <= 1'b0;
         lowest_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         clr_rsp_ff   <= clr_rsp_in;
         lowest_ff    <= lowest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_req_ff   <= cell_req_in;
      newp_ff       <= newp_in;
      oldp_ff       <= oldp_in;
      cur_ff        <= cur_in;
      steps_ff      <= steps_in;
      status_ff     <= status_in;
      popped_ff     <= popped_in;
      rsp_status_ff <= rsp_status_in;
      rsp_popped_ff <= rsp_popped_in;
   end

endmodule
`default_nettype wire
